// ===== src/mvt_pkg.sv =====
package mvt_pkg;

  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int NUM_ELEMS  = 4;
  localparam int ROW_W      = NUM_ELEMS * ELEM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  typedef logic signed [ELEM_W-1:0] elem_t;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_ROW_0 = 3'd1,
    REG_ROW_1 = 3'd2,
    REG_ROW_2 = 3'd3,
    REG_ROW_3 = 3'd4
  } cfg_reg_t;

  // Pipeline enables shared by all lanes
  typedef struct packed {
    logic load;   // capture products of a newly accepted item
    logic fold;   // reduce, scale and clamp the captured products
  } lane_ctl_t;

  // What one lane hands to the merging stage
  typedef struct packed {
    elem_t value;
    logic  sat;
  } lane_res_t;

endpackage

// ===== src/mvt_lane.sv =====
module mvt_lane #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  mvt_pkg::lane_ctl_t ctl,
  input  mvt_pkg::elem_t     coef [DIM],
  input  mvt_pkg::elem_t     vec  [DIM],
  output mvt_pkg::lane_res_t res
);
  import mvt_pkg::*;

  localparam int SUM_W = PROD_W + $clog2(DIM);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [PROD_W-1:0] prod_r   [DIM];
  logic signed [PROD_W-1:0] prod_nxt [DIM];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  lane_res_t                res_r;
  lane_res_t                res_nxt;

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      prod_nxt[j] = PROD_W'(coef[j]) * PROD_W'(vec[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= prod_nxt;
    end
  end

  // Arithmetic shift gives the floor for negative sums as well
  always_comb begin
    sum = '0;
    for (int j = 0; j < DIM; j++) begin
      sum = sum + SUM_W'(prod_r[j]);
    end
    shifted = sum >>> FRAC_BITS;
    if (shifted > SAT_HI) begin
      res_nxt.value = elem_t'(SAT_HI);
      res_nxt.sat   = 1'b1;
    end else if (shifted < SAT_LO) begin
      res_nxt.value = elem_t'(SAT_LO);
      res_nxt.sat   = 1'b1;
    end else begin
      res_nxt.value = elem_t'(shifted);
      res_nxt.sat   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fold) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== src/mvt_merge.sv =====
module mvt_merge #(
  parameter int DIM = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fold_done,
  input  mvt_pkg::lane_res_t res      [DIM],
  output logic               out_valid,
  output mvt_pkg::elem_t     out_elem [mvt_pkg::NUM_ELEMS],
  output logic               out_sat
);
  import mvt_pkg::*;

  logic  valid_r;
  elem_t elem_r   [NUM_ELEMS];
  elem_t elem_nxt [NUM_ELEMS];
  logic  sat_r;
  logic  sat_nxt;

  // Drop lanes beyond DIM to zero and gather the clamp flags
  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < NUM_ELEMS; i++) begin
      elem_nxt[i] = '0;
      if (i < DIM) begin
        elem_nxt[i] = res[i].value;
        sat_nxt     = sat_nxt | res[i].sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= fold_done;
    end
  end

  always_ff @(posedge clk) begin
    if (fold_done) begin
      elem_r <= elem_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_elem  = elem_r;
  assign out_sat   = sat_r;

endmodule

// ===== src/matrix_vector_transform_4x4_core.sv =====
// 4x4 matrix-vector transform, signed Q8.8 (FRAC_BITS fraction bits).
//
// Input channel: drive in_vec_x..in_vec_w and raise start; the item is
// taken at the rising edge where start is high and busy is low. busy
// stays low, so a new item may enter on every clock cycle.
// Result channel: out_valid is high for exactly one cycle with out_x..
// out_w and out_saturated; the result is taken at the edge ending that
// cycle. There is no back-pressure, so the receiver must take every item.
// Path: the product registers, the lane reduce/clamp registers and the
// merge registers lie between the accepting edge and the result; out_valid
// is registered in the merge stage together with out_x..out_w.
// Throughput: one item per cycle, set by one multiplier per matrix entry
// in every lane working in parallel.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// is the mode (bit 0 kept), 1..4 are matrix rows 0..3, higher indexes are
// ignored. cfg_ready is always high. Write only while no item is in flight.
// Reset (synchronous, rst_n low) flushes the pipeline, sets column mode
// and loads the identity matrix.
module matrix_vector_transform_4x4_core #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  mvt_pkg::elem_t                     in_vec_x,
  input  mvt_pkg::elem_t                     in_vec_y,
  input  mvt_pkg::elem_t                     in_vec_z,
  input  mvt_pkg::elem_t                     in_vec_w,
  output logic                               out_valid,
  output mvt_pkg::elem_t                     out_x,
  output mvt_pkg::elem_t                     out_y,
  output mvt_pkg::elem_t                     out_z,
  output mvt_pkg::elem_t                     out_w,
  output logic                               out_saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mvt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mvt_pkg::*;

  logic             mode_r;
  logic [ROW_W-1:0] matrix_r [NUM_ELEMS];
  logic             accept;
  logic             prod_valid_r;
  logic             fold_valid_r;
  lane_ctl_t        ctl;
  elem_t            vec_all  [NUM_ELEMS];
  elem_t            vec_lane [DIM];
  elem_t            coef     [DIM][DIM];
  lane_res_t        lane_res [DIM];
  elem_t            out_elem [NUM_ELEMS];

  // The pipeline never stalls, so the block is always ready
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration registers; reset loads the identity matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      for (int r = 0; r < NUM_ELEMS; r++) begin
        matrix_r[r] <= ROW_W'(1) << (ELEM_W * r + FRAC_BITS);
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:  mode_r      <= cfg_data[0];
        REG_ROW_0: matrix_r[0] <= cfg_data;
        REG_ROW_1: matrix_r[1] <= cfg_data;
        REG_ROW_2: matrix_r[2] <= cfg_data;
        REG_ROW_3: matrix_r[3] <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Advance the valid flags alongside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      fold_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= accept;
      fold_valid_r <= prod_valid_r;
    end
  end

  assign ctl.load = accept;
  assign ctl.fold = prod_valid_r;

  assign vec_all[0] = in_vec_x;
  assign vec_all[1] = in_vec_y;
  assign vec_all[2] = in_vec_z;
  assign vec_all[3] = in_vec_w;

  // Route matrix entries to lanes: lane i takes row i in column mode,
  // column i in row mode (the transpose)
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      vec_lane[i] = vec_all[i];
      for (int j = 0; j < DIM; j++) begin
        coef[i][j] = mode_r ? matrix_r[j][ELEM_W*i +: ELEM_W]
                            : matrix_r[i][ELEM_W*j +: ELEM_W];
      end
    end
  end

  for (genvar i = 0; i < DIM; i++) begin : g_lane
    mvt_lane #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .coef (coef[i]),
      .vec  (vec_lane),
      .res  (lane_res[i])
    );
  end

  mvt_merge #(
    .DIM (DIM)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .fold_done (fold_valid_r),
    .res       (lane_res),
    .out_valid (out_valid),
    .out_elem  (out_elem),
    .out_sat   (out_saturated)
  );

  assign out_x = out_elem[0];
  assign out_y = out_elem[1];
  assign out_z = out_elem[2];
  assign out_w = out_elem[3];

endmodule

// ===== src/mvt_checker.sv =====
module mvt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input mvt_pkg::elem_t out_x,
  input mvt_pkg::elem_t out_y,
  input mvt_pkg::elem_t out_z,
  input mvt_pkg::elem_t out_w,
  input logic           out_saturated
);

  // Every accepted item yields a result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted item produced no result");

  // No result without a matching accepted item
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without a matching item");

  // A clamp flag means some element sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_x == 16'sh7fff || out_x == -16'sh8000 ||
       out_y == 16'sh7fff || out_y == -16'sh8000 ||
       out_z == 16'sh7fff || out_z == -16'sh8000 ||
       out_w == 16'sh7fff || out_w == -16'sh8000))
    else $error("saturation flagged with no element at a rail");

  // Reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

bind matrix_vector_transform_4x4_core mvt_checker u_mvt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_x         (out_x),
  .out_y         (out_y),
  .out_z         (out_z),
  .out_w         (out_w),
  .out_saturated (out_saturated)
);
